FILE: hdl/u2rd_pkg.sv
// ----------------------------------------------------------------------------
// u2rd_pkg
// Shared types and constants for the unsigned to radix digits converter.
// ----------------------------------------------------------------------------
`default_nettype none

package u2rd_pkg;

   localparam int unsigned INPUT_BITS = 32;
   localparam int unsigned RADIX_BITS = 6;
   localparam int unsigned DIGIT_BITS = 6;
   localparam int unsigned CHAR_BITS  = 8;
   localparam int unsigned STEP_BITS  = 3;

   localparam logic [RADIX_BITS-1:0] RADIX_MIN = 6'd2;
   localparam logic [RADIX_BITS-1:0] RADIX_MAX = 6'd36;

   localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = 8'h30;
   localparam logic [CHAR_BITS-1:0] CHAR_ALPHA  = 8'h41;
   localparam logic [CHAR_BITS-1:0] CHAR_ERROR  = 8'h00;
   localparam logic [DIGIT_BITS-1:0] DEC_DIGITS = 6'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PMUL,
      ST_PCHK,
      ST_DIV,
      ST_EMIT,
      ST_RMUL
   } state_type;

   function automatic logic [CHAR_BITS-1:0] digit_to_char(input logic [DIGIT_BITS-1:0] d);
      logic [CHAR_BITS-1:0] c;
      if (d < DEC_DIGITS) begin
         c = CHAR_ZERO + CHAR_BITS'(d);
      end else begin
         c = CHAR_ALPHA + CHAR_BITS'(d - DEC_DIGITS);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

FILE: hdl/u2rd_if.sv
// ----------------------------------------------------------------------------
// u2rd channel interfaces
// Valid/ready channels for conversion requests and digit responses.
// ----------------------------------------------------------------------------
`default_nettype none

interface u2rd_req_if;
   logic                                valid;
   logic                                ready;
   logic [u2rd_pkg::INPUT_BITS-1:0]     value;
   logic [u2rd_pkg::RADIX_BITS-1:0]     radix;

   modport source (output valid, output value, output radix, input ready);
   modport sink   (input valid, input value, input radix, output ready);
endinterface

interface u2rd_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [u2rd_pkg::CHAR_BITS-1:0]      digit_char;
   logic                                last;
   logic                                bad_radix;

   modport source (output valid, output digit_char, output last, output bad_radix,
                   input ready);
   modport sink   (input valid, input digit_char, input last, input bad_radix,
                   output ready);
endinterface

`default_nettype wire

FILE: hdl/unsigned_to_radix_digits.sv
// ----------------------------------------------------------------------------
// unsigned_to_radix_digits
// Converts an unsigned number to ASCII digits in radix 2..36, most
// significant digit first, with a last flag on the final character.
// ----------------------------------------------------------------------------
//  channel   direction  payload                          handshake
//  req_ch    in         value[31:0], radix[5:0]          valid/ready
//  rsp_ch    out        digit_char[7:0], last, bad_radix valid/ready
//
//  An item runs a power search, each step a multiply (one shared multiplier,
//  registered product) and a check, then per digit a restoring division on
//  one shared subtractor, a quotient bit per step, an output state and a
//  multiply of the remainder. A bad radix goes straight to the output state.
//  Synchronous reset returns the sequencer to idle. req_ch is not ready while
//  an item is at work; a stalled rsp_ch holds the sequencer in its output state.
// ----------------------------------------------------------------------------
`default_nettype none

module unsigned_to_radix_digits #(
   parameter int unsigned VALUE_BITS = 32
) (
   input  wire       clock,
   input  wire       reset,
   u2rd_req_if.sink   req_ch,
   u2rd_rsp_if.source rsp_ch
);

   localparam int unsigned WIDE_BITS = VALUE_BITS + u2rd_pkg::RADIX_BITS;
   localparam int unsigned CNT_BITS  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
   localparam int unsigned EXT_BITS  = VALUE_BITS + u2rd_pkg::INPUT_BITS;

   u2rd_pkg::state_type state_ff, state_in;

   logic [VALUE_BITS-1:0]                 p_ff;
   logic [WIDE_BITS-1:0]                  rem_ff;
   logic [WIDE_BITS-1:0]                  prod_ff;
   logic [u2rd_pkg::RADIX_BITS-1:0]       radix_ff;
   logic [u2rd_pkg::DIGIT_BITS-1:0]       digit_ff;
   logic [u2rd_pkg::STEP_BITS-1:0]        step_ff;
   logic [CNT_BITS-1:0]                   cnt_ff;
   logic                                  bad_ff;

   logic                                  req_fire;
   logic                                  rsp_fire;
   logic                                  radix_ok;
   logic                                  last_digit;
   logic                                  div_done;
   logic                                  pow_fits;
   logic [EXT_BITS-1:0]                   value_ext;
   logic [VALUE_BITS-1:0]                 value_v;
   logic [VALUE_BITS-1:0]                 mult_a;
   logic [WIDE_BITS-1:0]                  product;
   logic [WIDE_BITS-1:0]                  divisor;
   logic [WIDE_BITS:0]                    trial;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_fire   = rsp_ch.valid && rsp_ch.ready;
   assign radix_ok   = req_ch.radix inside {[u2rd_pkg::RADIX_MIN:u2rd_pkg::RADIX_MAX]};
   assign last_digit = (cnt_ff == '0);
   assign div_done   = (step_ff == '0);
   assign pow_fits   = (prod_ff <= rem_ff);
   assign value_ext  = {{VALUE_BITS{1'b0}}, req_ch.value};
   assign value_v    = value_ext[VALUE_BITS-1:0];

   // shared multiplier: powers of the radix during search, remainder later
   assign mult_a  = (state_ff == u2rd_pkg::ST_RMUL) ? rem_ff[VALUE_BITS-1:0] : p_ff;
   assign product = WIDE_BITS'(mult_a) * WIDE_BITS'(radix_ff);

   // shared subtractor: one quotient bit per cycle
   assign divisor = WIDE_BITS'(p_ff) << step_ff;
   assign trial   = {1'b0, rem_ff} - {1'b0, divisor};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         u2rd_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = radix_ok ? u2rd_pkg::ST_PMUL : u2rd_pkg::ST_EMIT;
            end
         end
         u2rd_pkg::ST_PMUL: state_in = u2rd_pkg::ST_PCHK;
         u2rd_pkg::ST_PCHK: state_in = pow_fits ? u2rd_pkg::ST_PMUL : u2rd_pkg::ST_DIV;
         u2rd_pkg::ST_DIV: begin
            if (div_done) begin
               state_in = u2rd_pkg::ST_EMIT;
            end
         end
         u2rd_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               state_in = last_digit ? u2rd_pkg::ST_IDLE : u2rd_pkg::ST_RMUL;
            end
         end
         u2rd_pkg::ST_RMUL: state_in = u2rd_pkg::ST_DIV;
         default: state_in = u2rd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_ch.ready      = (state_ff == u2rd_pkg::ST_IDLE);
      rsp_ch.valid      = (state_ff == u2rd_pkg::ST_EMIT);
      rsp_ch.last       = bad_ff || last_digit;
      rsp_ch.bad_radix  = bad_ff;
      rsp_ch.digit_char = bad_ff ? u2rd_pkg::CHAR_ERROR : u2rd_pkg::digit_to_char(digit_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= u2rd_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         u2rd_pkg::ST_IDLE: begin
            if (req_fire) begin
               radix_ff <= req_ch.radix;
               rem_ff   <= WIDE_BITS'(value_v);
               p_ff     <= VALUE_BITS'(1);
               cnt_ff   <= '0;
               digit_ff <= '0;
               bad_ff   <= !radix_ok;
            end
         end
         u2rd_pkg::ST_PMUL: begin
            prod_ff <= product;
         end
         u2rd_pkg::ST_PCHK: begin
            step_ff  <= u2rd_pkg::STEP_BITS'(u2rd_pkg::DIGIT_BITS - 1);
            digit_ff <= '0;
            if (pow_fits) begin
               p_ff   <= prod_ff[VALUE_BITS-1:0];
               cnt_ff <= cnt_ff + CNT_BITS'(1);
            end
         end
         u2rd_pkg::ST_DIV: begin
            if (!trial[WIDE_BITS]) begin
               rem_ff            <= trial[WIDE_BITS-1:0];
               digit_ff[step_ff] <= 1'b1;
            end
            step_ff <= step_ff - u2rd_pkg::STEP_BITS'(1);
         end
         u2rd_pkg::ST_EMIT: begin
            if (rsp_fire && !last_digit) begin
               cnt_ff <= cnt_ff - CNT_BITS'(1);
            end
         end
         u2rd_pkg::ST_RMUL: begin
            rem_ff   <= product;
            digit_ff <= '0;
            step_ff  <= u2rd_pkg::STEP_BITS'(u2rd_pkg::DIGIT_BITS - 1);
         end
         default: begin
            bad_ff <= bad_ff;
         end
      endcase
   end

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_ch.ready)
      else $error("request channel ready while an item is at work");

   a_bad_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && rsp_ch.bad_radix) |-> rsp_ch.last)
      else $error("bad radix response not marked last");

   a_digit_below_radix: assert property (@(posedge clock) disable iff (reset)
      (rsp_ch.valid && !rsp_ch.bad_radix) |-> (digit_ff < radix_ff))
      else $error("digit not below radix");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_ch.last) |=> req_ch.ready)
      else $error("not idle after final character");

endmodule

`default_nettype wire
